/* rtl/frame_rate_meter_limiter_assert.svh */
// Assertion macros for the frame rate meter; clk and rst_n are taken from the using module.
`ifndef FRAME_RATE_METER_LIMITER_ASSERT_SVH
`define FRAME_RATE_METER_LIMITER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRML_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FRML_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/frml_pkg.sv */
package frml_pkg;

  localparam int WINDOW_DEF     = 100;
  localparam int TIME_W         = 32;
  localparam int MAX_FPS_W      = 10;
  localparam int FPS_W          = 25;
  localparam int FRAME_W        = 16;
  localparam int DELAY_W        = 10;
  localparam int RATE_SCALE     = 256000;  // 1000 ms per second, scaled by 2^8
  localparam int PERIOD_MS      = 1000;
  localparam int MAX_FPS_RST    = 60;
  localparam int FPS_DEFAULT_Q8 = 60 * 256;
  localparam int FPS_MAX_Q8     = (1 << FPS_W) - 1;
  localparam int SCALE_W        = 18;      // bits of RATE_SCALE

  localparam logic REQ_BEGIN = 1'b0;
  localparam logic REQ_END   = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* rtl/frml_if.sv */
interface frml_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [frml_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, req_type, now_ms, input ready);
  modport sink   (input valid, req_type, now_ms, output ready);
endinterface

interface frml_out_if;
  logic                          valid;
  logic                          ready;
  logic [frml_pkg::FPS_W-1:0]    fps_q8;
  logic [frml_pkg::FRAME_W-1:0]  frame_time_ms;
  logic [frml_pkg::DELAY_W-1:0]  delay_ms;

  modport source (output valid, fps_q8, frame_time_ms, delay_ms, input ready);
  modport sink   (input valid, fps_q8, frame_time_ms, delay_ms, output ready);
endinterface

interface frml_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [frml_pkg::MAX_FPS_W-1:0]  max_fps;

  modport source (output valid, max_fps, input ready);
  modport sink   (input valid, max_fps, output ready);
endinterface

/* rtl/frml_ram.sv */
module frml_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 100,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/frml_div.sv */
// Restoring divider, one quotient bit per cycle.
module frml_div #(
  parameter int N_W = 25,
  parameter int D_W = 23
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [N_W-1:0]      dividend,
  input  logic [D_W-1:0]      divisor,
  output logic [N_W-1:0]      quotient,
  output frml_pkg::div_sts_t  sts
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [N_W-1:0]   dvd_r;
  logic [D_W-1:0]   dvs_r;
  logic [D_W-1:0]   rem_r;

  logic [D_W:0]     trial;
  logic             qbit;
  logic [D_W-1:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[N_W-1]};
    qbit    = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? D_W'(trial - {1'b0, dvs_r}) : trial[D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= CNT_W'(N_W);
      end else if (busy_r) begin
        cnt_r  <= cnt_r - 1'b1;
        busy_r <= (cnt_r != CNT_W'(1));
        done_r <= (cnt_r == CNT_W'(1));
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[N_W-2:0], qbit};
    end
  end

  assign quotient = dvd_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* rtl/frame_rate_meter_limiter.sv */
// Frame rate meter and limiter. A frame-begin transaction only records its time and gives no
// result. A frame-end transaction stores its interval in a ring of the last WINDOW intervals
// (a RAM read in the accepting cycle and written back in the next) and then runs the divisions
// on one shared bit-serial divider: the frame period 1000/max_fps and, while the interval sum
// is nonzero, the rate 256000*count/sum. After a frame end in_ch.ready stays low until the
// result is loaded into the output register, so no new transaction is accepted while the
// divisions run; a result still waiting there for out_ch.ready holds off that load. The ring
// needs no clearing after reset; only entries already written are ever used. The output
// register holds one result while the next frame is being processed. The user is to write
// max_fps through cfg_ch only while the block is idle; the block itself does not enforce this.
`include "frame_rate_meter_limiter_assert.svh"

module frame_rate_meter_limiter #(
  parameter int WINDOW = frml_pkg::WINDOW_DEF
) (
  input logic        clk,
  input logic        rst_n,
  frml_in_if.sink    in_ch,
  frml_out_if.source out_ch,
  frml_cfg_if.sink   cfg_ch
);

  localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = frml_pkg::FRAME_W + CNT_W;
  localparam int NUM_W   = (frml_pkg::SCALE_W + CNT_W > frml_pkg::FPS_W) ?
                           frml_pkg::SCALE_W + CNT_W : frml_pkg::FPS_W;
  localparam int TIME_W  = frml_pkg::TIME_W;
  localparam int FRAME_W = frml_pkg::FRAME_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_PER  = 3'd2;
  localparam logic [2:0] S_FPS  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                     state_r;
  logic [frml_pkg::MAX_FPS_W-1:0] max_fps_r;
  logic [SUM_W-1:0]               sum_r;
  logic [IDX_W-1:0]               widx_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [TIME_W-1:0]              prev_end_r;
  logic                           seen_end_r;
  logic [TIME_W-1:0]              start_ms_r;
  logic [TIME_W-1:0]              now_r;
  logic [FRAME_W-1:0]             gap_r;
  logic [NUM_W-1:0]               num_r;
  logic [frml_pkg::FPS_W-1:0]     fps_r;
  logic [frml_pkg::DELAY_W-1:0]   delay_r;
  logic                           out_valid_r;
  logic [frml_pkg::FPS_W-1:0]     out_fps_r;
  logic [FRAME_W-1:0]             out_frame_r;
  logic [frml_pkg::DELAY_W-1:0]   out_delay_r;

  logic                 in_acc;
  logic                 end_acc;
  logic [TIME_W-1:0]    diff;
  logic [FRAME_W-1:0]   gap_nxt;
  logic                 ring_full;
  logic [FRAME_W-1:0]   old_gap;
  logic [SUM_W-1:0]     sum_nxt;
  logic [CNT_W-1:0]     cnt_nxt;
  logic [TIME_W-1:0]    busy_ms;
  logic [TIME_W-1:0]    period;
  logic [frml_pkg::DELAY_W-1:0] delay_nxt;
  logic [frml_pkg::FPS_W-1:0]   fps_sat;
  logic                 out_load;

  logic                 div_start;
  logic [NUM_W-1:0]     div_dvd;
  logic [SUM_W-1:0]     div_dvs;
  logic [NUM_W-1:0]     div_q;
  frml_pkg::div_sts_t   div_sts;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign end_acc  = in_acc && (in_ch.req_type == frml_pkg::REQ_END);
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Interval since the previous end, saturated; zero for the first end.
  always_comb begin
    diff    = in_ch.now_ms - prev_end_r;
    gap_nxt = '0;
    if (seen_end_r) begin
      gap_nxt = (|diff[TIME_W-1:FRAME_W]) ? {FRAME_W{1'b1}} : diff[FRAME_W-1:0];
    end
  end

  // Running sum: drop the oldest interval once the ring is full.
  always_comb begin
    ring_full = (cnt_r == CNT_W'(WINDOW));
    sum_nxt   = sum_r + SUM_W'(gap_r) - (ring_full ? SUM_W'(old_gap) : '0);
    cnt_nxt   = ring_full ? cnt_r : cnt_r + 1'b1;
  end

  always_comb begin
    busy_ms   = now_r - start_ms_r;
    period    = TIME_W'(div_q);
    delay_nxt = (period > busy_ms) ? frml_pkg::DELAY_W'(period - busy_ms) : '0;
    fps_sat   = (div_q > NUM_W'(frml_pkg::FPS_MAX_Q8)) ?
                frml_pkg::FPS_W'(frml_pkg::FPS_MAX_Q8) : div_q[frml_pkg::FPS_W-1:0];
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = num_r;
    div_dvs   = sum_r;
    case (state_r)
      S_UPD: begin
        div_start = 1'b1;
        div_dvd   = NUM_W'(frml_pkg::PERIOD_MS);
        div_dvs   = (max_fps_r == '0) ? SUM_W'(1) : SUM_W'(max_fps_r);
      end
      S_PER: begin
        div_start = div_sts.done && (sum_r != '0);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  frml_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == S_UPD),
    .waddr (widx_r),
    .wdata (gap_r),
    .re    (end_acc),
    .raddr (widx_r),
    .rdata (old_gap)
  );

  frml_div #(
    .N_W (NUM_W),
    .D_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .sts      (div_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_fps_r   <= frml_pkg::MAX_FPS_W'(frml_pkg::MAX_FPS_RST);
      sum_r       <= '0;
      widx_r      <= '0;
      cnt_r       <= '0;
      prev_end_r  <= '0;
      seen_end_r  <= 1'b0;
      start_ms_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        max_fps_r <= cfg_ch.max_fps;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_ch.req_type == frml_pkg::REQ_BEGIN)) begin
            start_ms_r <= in_ch.now_ms;
          end
          if (end_acc) begin
            prev_end_r <= in_ch.now_ms;
            seen_end_r <= 1'b1;
            state_r    <= S_UPD;
          end
        end
        S_UPD: begin
          sum_r   <= sum_nxt;
          cnt_r   <= cnt_nxt;
          widx_r  <= (widx_r == IDX_W'(WINDOW - 1)) ? '0 : widx_r + 1'b1;
          state_r <= S_PER;
        end
        S_PER: begin
          if (div_sts.done) begin
            state_r <= (sum_r == '0) ? S_OUT : S_FPS;
          end
        end
        S_FPS: begin
          if (div_sts.done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (end_acc) begin
      now_r <= in_ch.now_ms;
      gap_r <= gap_nxt;
    end
    if (state_r == S_UPD) begin
      num_r <= NUM_W'(frml_pkg::RATE_SCALE) * NUM_W'(cnt_nxt);
    end
    if ((state_r == S_PER) && div_sts.done) begin
      delay_r <= delay_nxt;
      fps_r   <= frml_pkg::FPS_W'(frml_pkg::FPS_DEFAULT_Q8);
    end
    if ((state_r == S_FPS) && div_sts.done) begin
      fps_r <= fps_sat;
    end
    if (out_load) begin
      out_fps_r   <= fps_r;
      out_frame_r <= gap_r;
      out_delay_r <= delay_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fps_q8        = out_fps_r;
  assign out_ch.frame_time_ms = out_frame_r;
  assign out_ch.delay_ms      = out_delay_r;

  `FRML_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(WINDOW), "sample count above window")
  `FRML_ASSERT_SAME(a_widx_bound, 1'b1, widx_r <= IDX_W'(WINDOW - 1), "ring index out of range")
  `FRML_ASSERT_SAME(a_empty_sum, cnt_r == '0, sum_r == '0, "nonzero sum with empty ring")
  `FRML_ASSERT_SAME(a_div_free, div_start, !div_sts.busy, "divider started while busy")
  `FRML_ASSERT_NEXT(a_upd_to_per, state_r == S_UPD, state_r == S_PER && div_sts.busy,
                    "period division not launched after ring update")

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WINDOW          = frml_pkg::WINDOW_DEF;
  localparam int          RESET_CYCLES    = 8;
  localparam int          SETTLE_CYCLES   = 80;
  localparam int          PHASES          = 5;
  localparam int          ITEMS_PER_PHASE = 250;
  localparam int unsigned CYCLE_LIMIT     = 1_500_000;

  typedef struct packed {
    logic [frml_pkg::FPS_W-1:0]   fps_q8;
    logic [frml_pkg::FRAME_W-1:0] frame_time_ms;
    logic [frml_pkg::DELAY_W-1:0] delay_ms;
  } frame_result_t;

  typedef enum logic {ROW_EVENT, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic                           req;
    logic [frml_pkg::TIME_W-1:0]    ts;
    logic [frml_pkg::MAX_FPS_W-1:0] fps_limit;
    logic                           typed;
    frame_result_t                  result;
  } stim_row_t;

  logic clk;
  logic rst_n;

  frml_in_if  in_ch();
  frml_out_if out_ch();
  frml_cfg_if cfg_ch();

  frame_rate_meter_limiter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Frame meter state as the block should hold it
  logic [frml_pkg::FRAME_W-1:0]   gap_ring [WINDOW];
  logic [22:0]                    gap_total;
  int unsigned                    ring_slot;
  int unsigned                    ring_fill;
  logic [frml_pkg::TIME_W-1:0]    last_end_ms;
  logic                           have_end;
  logic [frml_pkg::TIME_W-1:0]    begin_ms;
  logic [frml_pkg::MAX_FPS_W-1:0] fps_limit;

  frame_result_t pending_results [$];
  stim_row_t     directed_rows [$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   ready_hold = 0;
  bit            steady;

  function automatic bit advance_model(input logic req, input logic [frml_pkg::TIME_W-1:0] ts,
                                       output frame_result_t res);
    logic [31:0] gap;
    logic [31:0] busy;
    logic [31:0] period;
    logic [31:0] divisor;
    logic [63:0] rate;
    res = '0;
    if (req == frml_pkg::REQ_BEGIN) begin
      begin_ms = ts;
      return 1'b0;
    end
    gap = have_end ? ts - last_end_ms : 32'd0;
    if (gap > 32'd65535) gap = 32'd65535;
    last_end_ms = ts;
    have_end = 1'b1;
    // Retire the oldest interval once the window is full
    if (ring_fill == WINDOW) gap_total = gap_total - gap_ring[ring_slot];
    else ring_fill++;
    gap_ring[ring_slot] = gap[frml_pkg::FRAME_W-1:0];
    gap_total = gap_total + gap[22:0];
    ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
    if (gap_total == 0) begin
      rate = 64'(frml_pkg::FPS_DEFAULT_Q8);
    end else begin
      rate = (64'(frml_pkg::RATE_SCALE) * 64'(ring_fill)) / 64'(gap_total);
      if (rate > 64'(frml_pkg::FPS_MAX_Q8)) rate = 64'(frml_pkg::FPS_MAX_Q8);
    end
    divisor = (fps_limit == '0) ? 32'd1 : 32'(fps_limit);
    period = 32'(frml_pkg::PERIOD_MS) / divisor;
    busy = ts - begin_ms;
    res.fps_q8 = rate[frml_pkg::FPS_W-1:0];
    res.frame_time_ms = gap[frml_pkg::FRAME_W-1:0];
    res.delay_ms = (period > busy) ? frml_pkg::DELAY_W'(period - busy) : '0;
    return 1'b1;
  endfunction

  function automatic int sender_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [frml_pkg::TIME_W-1:0] frame_step();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 40);
    if (roll < 90) return $urandom_range(41, 1200);
    if (roll < 97) return $urandom_range(60000, 70000);
    return $urandom();
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Hold valid across back-to-back transactions; lower it only ahead of a gap
  task automatic push_event(input logic req, input logic [frml_pkg::TIME_W-1:0] ts,
                            input logic typed, input frame_result_t typed_res);
    int            gap;
    frame_result_t predicted;
    gap = sender_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.now_ms   <= ts;
    do @(posedge clk); while (!in_ch.ready);
    if (advance_model(req, ts, predicted))
      pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic write_fps_limit(input logic [frml_pkg::MAX_FPS_W-1:0] value);
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.max_fps <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    fps_limit = value;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("frame_rate_meter_limiter test failed");
      $finish;
    end
  end

  always @(posedge clk) begin : drive_result_ready
    int unsigned roll;
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (!steady) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) ready_hold = $urandom_range(1, 3);
      else if (roll < 10) ready_hold = $urandom_range(20, 150);
    end
    out_ch.ready <= rst_n && (steady || ready_hold == 0);
  end

  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $error("result transaction with no frame end waiting");
      end else begin
        want = pending_results.pop_front();
        if (out_ch.fps_q8 !== want.fps_q8) begin
          mismatch_count++;
          $error("fps_q8 expected %0d actual %0d", want.fps_q8, out_ch.fps_q8);
        end
        if (out_ch.frame_time_ms !== want.frame_time_ms) begin
          mismatch_count++;
          $error("frame_time_ms expected %0d actual %0d", want.frame_time_ms,
                 out_ch.frame_time_ms);
        end
        if (out_ch.delay_ms !== want.delay_ms) begin
          mismatch_count++;
          $error("delay_ms expected %0d actual %0d", want.delay_ms, out_ch.delay_ms);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned                    roll;
    int unsigned                    sent;
    int unsigned                    repeats;
    logic [frml_pkg::MAX_FPS_W-1:0] limit_value;
    logic [frml_pkg::TIME_W-1:0]    clock_ms;

    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.req_type <= frml_pkg::REQ_BEGIN;
    in_ch.now_ms   <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.max_fps <= '0;
    steady         = 1'b0;
    gap_total      = '0;
    ring_slot      = 0;
    ring_fill      = 0;
    last_end_ms    = '0;
    have_end       = 1'b0;
    begin_ms       = '0;
    fps_limit      = frml_pkg::MAX_FPS_W'(frml_pkg::MAX_FPS_RST);

    // Period is 16 ms at the reset limit of 60 fps
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_BEGIN, 32'd0, 10'd0, 1'b0, '0});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_END, 32'd5, 10'd0, 1'b1,
                              '{25'd15360, 16'd0, 10'd11}});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_BEGIN, 32'd10, 10'd0, 1'b0, '0});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_END, 32'd15, 10'd0, 1'b1,
                              '{25'd51200, 16'd10, 10'd11}});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_END, 32'd15, 10'd0, 1'b1,
                              '{25'd76800, 16'd0, 10'd11}});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_END, 32'd65551, 10'd0, 1'b1,
                              '{25'd15, 16'd65535, 10'd0}});
    // Tick wrap between begin and end
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_BEGIN, 32'hFFFF_FFF0, 10'd0, 1'b0, '0});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_END, 32'h0000_0003, 10'd0, 1'b0, '0});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_BEGIN, 32'hFFFF_FFFF, 10'd0, 1'b0, '0});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_END, 32'hFFFF_FFFF, 10'd0, 1'b0, '0});
    directed_rows.push_back('{ROW_CONFIG, frml_pkg::REQ_BEGIN, 32'd0, 10'd1000, 1'b0, '0});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_BEGIN, 32'd0, 10'd0, 1'b0, '0});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_END, 32'd0, 10'd0, 1'b0, '0});
    // A zero limit counts as one frame per second
    directed_rows.push_back('{ROW_CONFIG, frml_pkg::REQ_BEGIN, 32'd0, 10'd0, 1'b0, '0});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_BEGIN, 32'd100, 10'd0, 1'b0, '0});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_END, 32'd100, 10'd0, 1'b0, '0});
    directed_rows.push_back('{ROW_CONFIG, frml_pkg::REQ_BEGIN, 32'd0, 10'd1023, 1'b0, '0});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_BEGIN, 32'd200, 10'd0, 1'b0, '0});
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_END, 32'd200, 10'd0, 1'b0, '0});
    directed_rows.push_back('{ROW_CONFIG, frml_pkg::REQ_BEGIN, 32'd0, 10'd1, 1'b0, '0});
    // End with no fresh begin measures busy time from the older begin
    directed_rows.push_back('{ROW_EVENT, frml_pkg::REQ_END, 32'd250, 10'd0, 1'b0, '0});
    directed_rows.push_back('{ROW_CONFIG, frml_pkg::REQ_BEGIN, 32'd0, 10'd60, 1'b0, '0});

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG)
        write_fps_limit(directed_rows[i].fps_limit);
      else
        push_event(directed_rows[i].req, directed_rows[i].ts, directed_rows[i].typed,
                   directed_rows[i].result);
    end

    clock_ms = 32'd1000;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: limit_value = frml_pkg::MAX_FPS_W'($urandom_range(1, 1000));
        1: limit_value = 10'd1000;
        2: limit_value = frml_pkg::MAX_FPS_W'($urandom());
        3: limit_value = 10'd1;
        default: limit_value = frml_pkg::MAX_FPS_W'($urandom_range(20, 240));
      endcase
      write_fps_limit(limit_value);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        steady = (sent < 60);
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          clock_ms = clock_ms + frame_step();
          push_event(frml_pkg::REQ_BEGIN, clock_ms, 1'b0, '0);
          clock_ms = clock_ms + frame_step();
          push_event(frml_pkg::REQ_END, clock_ms, 1'b0, '0);
          sent += 2;
        end else if (roll < 80) begin
          clock_ms = clock_ms + frame_step();
          push_event(frml_pkg::REQ_END, clock_ms, 1'b0, '0);
          sent++;
        end else if (roll < 86) begin
          clock_ms = clock_ms + frame_step();
          push_event(frml_pkg::REQ_BEGIN, clock_ms, 1'b0, '0);
          sent++;
        end else if (roll < 92) begin
          // Zero intervals pull the window sum down
          repeats = $urandom_range(2, 4);
          repeat (repeats) push_event(frml_pkg::REQ_END, clock_ms, 1'b0, '0);
          sent += repeats;
        end else if (roll < 98) begin
          push_event(1'($urandom_range(0, 1)), $urandom(), 1'b0, '0);
          sent++;
        end else begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          wait_drained();
        end
      end
      steady = 1'b0;
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("frame_rate_meter_limiter test passed");
    end else begin
      $display("frame_rate_meter_limiter test failed");
    end
    $finish;
  end

endmodule
